// File: rtl/core/aps_pkg.sv
// shared types and constants for the aging pool with timed expiry
package aps_pkg;

   localparam int LINK_W = 7;
   localparam int NUM_W = 40;
   localparam logic [31:0] DEFAULT_LIFETIME = 32'd20000;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_SWEEP = 1'b1;
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_LIVE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_CHECK,
      ST_EV_RD,
      ST_EV_CHK,
      ST_EV_W2,
      ST_POP_RD,
      ST_POP_W,
      ST_LINK,
      ST_S_RD,
      ST_S_EVAL,
      ST_S_UNL2,
      ST_S_MUL,
      ST_S_DIV,
      ST_S_WB,
      ST_S_END
   } state_type;

   typedef struct packed {
      logic [30:0] stamp;
      logic [31:0] life;
      logic [15:0] handle;
      logic [31:0] color;
      logic [31:0] shown;
      logic        fade;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [LINK_W-1:0] addr;
      logic [LINK_W-1:0] data;
   } link_wr_type;

   typedef struct packed {
      logic [LINK_W-1:0] newer;
      logic [LINK_W-1:0] older;
      logic [LINK_W-1:0] free;
   } link_rd_type;

   typedef struct packed {
      logic        opcode;
      logic [30:0] now;
      logic [31:0] life;
      logic        fade;
      logic [15:0] handle;
      logic [31:0] color;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [5:0]  slot;
      logic [15:0] handle;
      logic [31:0] color;
      logic [6:0]  evicted;
      logic        last;
   } result_type;

endpackage

// File: rtl/core/aps_entry_mem.sv
// entry payload memory, one write and one registered read port
module aps_entry_mem
   import aps_pkg::*;
#(
   parameter int POOL_SIZE = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [LINK_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [LINK_W-1:0] rd_addr,
   output entry_type         rd_data
);
   localparam int IW = $clog2(POOL_SIZE);

   entry_type mem [POOL_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[IW-1:0]] <= wr_data;
      end
      rd_data <= mem[rd_addr[IW-1:0]];
   end
endmodule

// File: rtl/core/aps_link_mem.sv
// newer, older and free link memories with free stack reset by valid bits
module aps_link_mem
   import aps_pkg::*;
#(
   parameter int POOL_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  link_wr_type       newer_wr,
   input  link_wr_type       older_wr,
   input  link_wr_type       free_wr,
   input  logic [LINK_W-1:0] rd_addr,
   input  logic [LINK_W-1:0] free_rd_addr,
   output link_rd_type       rd_data
);
   localparam int IW = $clog2(POOL_SIZE);

   logic [LINK_W-1:0] newer_mem [POOL_SIZE];
   logic [LINK_W-1:0] older_mem [POOL_SIZE];
   logic [LINK_W-1:0] free_mem [POOL_SIZE];
   logic [POOL_SIZE-1:0] free_valid_ff;
   logic [LINK_W-1:0] newer_rd_ff, older_rd_ff, free_rd_ff, free_addr_ff;
   logic              free_vld_rd_ff;

   always_ff @(posedge clock) begin
      if (newer_wr.we) begin
         newer_mem[newer_wr.addr[IW-1:0]] <= newer_wr.data;
      end
      if (older_wr.we) begin
         older_mem[older_wr.addr[IW-1:0]] <= older_wr.data;
      end
      if (free_wr.we) begin
         free_mem[free_wr.addr[IW-1:0]] <= free_wr.data;
      end
      newer_rd_ff <= newer_mem[rd_addr[IW-1:0]];
      older_rd_ff <= older_mem[rd_addr[IW-1:0]];
      free_rd_ff <= free_mem[free_rd_addr[IW-1:0]];
      free_vld_rd_ff <= free_valid_ff[free_rd_addr[IW-1:0]];
      free_addr_ff <= free_rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_valid_ff <= '0;
      end else if (free_wr.we) begin
         free_valid_ff[free_wr.addr[IW-1:0]] <= 1'b1;
      end
   end

   // an unwritten free link points at the next slot up
   assign rd_data.newer = newer_rd_ff;
   assign rd_data.older = older_rd_ff;
   assign rd_data.free = free_vld_rd_ff ? free_rd_ff : free_addr_ff + LINK_W'(1);
endmodule

// File: rtl/core/aps_div.sv
// bit-serial restoring divider for an 8-bit quotient
module aps_div
   import aps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [31:0]      den,
   output logic             done,
   output logic [7:0]       quo
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [7:0]  q_ff, q_in;
   logic [32:0] sh;
   logic        ge;

   always_comb begin
      sh = {rem_ff, q_ff[7]};
      ge = sh >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 3'd7;
         rem_in = num[NUM_W-1:8];
         q_in = num[7:0];
      end else if (busy_ff) begin
         rem_in = ge ? 32'(sh - {1'b0, den}) : sh[31:0];
         q_in = {q_ff[6:0], ge};
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quo = q_ff;
endmodule

// File: rtl/core/aging_pool_with_timed_expiry_unit.sv
// top level: pool sequencer, list maintenance and fade datapath
// A transaction is taken when start is high, busy is low and the unit is
// enabled through the csr port; busy stays high until its work is done. An
// allocate with no free slot first evicts from the oldest end, stopping at
// an entry with a different stamp. A sweep frees expired entries, reports
// the others and fades those past half their life on the shared serial
// divider, once for alpha fade and once per channel for colour fade.
// Results appear on the rsp_ ports for one cycle, marked by rsp_valid, and
// cannot be held off; every result must be taken in the cycle it is shown.
module aging_pool_with_timed_expiry_unit
   import aps_pkg::*;
#(
   parameter int POOL_SIZE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [30:0] req_current_time,
   input  logic signed [31:0] req_duration,
   input  logic        req_alpha_fade,
   input  logic [15:0] req_shader_handle,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   input  logic        csr_we,
   input  logic        csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [5:0]  rsp_slot,
   output logic [15:0] rsp_handle_out,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out,
   output logic [6:0]  rsp_evicted_count,
   output logic        rsp_last
);
   localparam logic [LINK_W-1:0] NONE = LINK_W'(POOL_SIZE);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   entry_type ent_ff, ent_in;
   result_type pend_ff, pend_in, rsp_ff, rsp_in;
   logic      pend_vld_ff, pend_vld_in, rsp_vld_ff, rsp_vld_in;
   logic      enabled_ff;
   logic [LINK_W-1:0] free_top_ff, free_top_in, newest_ff, newest_in;
   logic [LINK_W-1:0] oldest_ff, oldest_in, cur_ff, cur_in;
   logic [LINK_W-1:0] n_ff, n_in, o_ff, o_in;
   logic [30:0] t0_ff, t0_in;
   logic        first_ff, first_in;
   logic [6:0]  evict_ff, evict_in;
   logic [32:0] t_ff, t_in;
   logic [1:0]  ch_ff, ch_in;

   entry_type   ent_rd, ent_wd;
   logic        ent_we;
   logic [LINK_W-1:0] ent_wa, rd_addr, free_rd_addr;
   link_wr_type newer_wr, older_wr, free_wr;
   link_rd_type lnk_rd;
   logic        div_start, div_done;
   logic [7:0]  quo;
   logic [NUM_W-1:0] num;
   logic [32:0] end_time, t_now;
   logic        expired, fade_now, ev_match;
   logic [LINK_W-1:0] oldest_nx;
   logic [7:0]  chan;

   aps_entry_mem #(.POOL_SIZE(POOL_SIZE)) u_entry (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_addr(rd_addr), .rd_data(ent_rd)
   );

   aps_link_mem #(.POOL_SIZE(POOL_SIZE)) u_link (
      .clock(clock), .reset(reset), .newer_wr(newer_wr), .older_wr(older_wr),
      .free_wr(free_wr), .rd_addr(rd_addr), .free_rd_addr(free_rd_addr),
      .rd_data(lnk_rd)
   );

   aps_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(num),
      .den(ent_ff.life), .done(div_done), .quo(quo)
   );

   always_comb begin
      end_time = {2'b00, ent_rd.stamp} + {1'b0, ent_rd.life};
      expired = {2'b00, req_ff.now} > end_time;
      t_now = end_time - {2'b00, req_ff.now};
      fade_now = {t_now, 1'b0} < {2'b00, ent_rd.life};
      ev_match = first_ff || (ent_rd.stamp == t0_ff);
      oldest_nx = (o_ff < NONE) ? oldest_ff : n_ff;
      case (ch_ff)
         2'd0: chan = ent_ff.color[7:0];
         2'd1: chan = ent_ff.color[15:8];
         default: chan = ent_ff.color[23:16];
      endcase
      if (ent_ff.fade) begin
         num = NUM_W'({9'd0, t_ff[30:0]} * 40'd510);
      end else begin
         num = NUM_W'(({9'd0, t_ff[30:0]} * {32'd0, chan}) << 1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && enabled_ff) begin
               if (req_opcode == OP_ALLOC) begin
                  state_in = ST_A_CHECK;
               end else begin
                  state_in = (newest_ff < NONE) ? ST_S_RD : ST_S_END;
               end
            end
         end
         ST_A_CHECK: begin
            state_in = (free_top_ff >= NONE && oldest_ff < NONE) ? ST_EV_RD : ST_POP_RD;
         end
         ST_EV_RD: state_in = ST_EV_CHK;
         ST_EV_CHK: state_in = ev_match ? ST_EV_W2 : ST_POP_RD;
         ST_EV_W2: state_in = (oldest_nx < NONE) ? ST_EV_RD : ST_POP_RD;
         ST_POP_RD: state_in = (free_top_ff >= NONE) ? ST_IDLE : ST_POP_W;
         ST_POP_W: state_in = ST_LINK;
         ST_LINK: state_in = ST_IDLE;
         ST_S_RD: state_in = ST_S_EVAL;
         ST_S_EVAL: begin
            if (expired) begin
               state_in = ST_S_UNL2;
            end else if (fade_now) begin
               state_in = ST_S_MUL;
            end else begin
               state_in = (lnk_rd.older < NONE) ? ST_S_RD : ST_S_END;
            end
         end
         ST_S_UNL2: state_in = (o_ff < NONE) ? ST_S_RD : ST_S_END;
         ST_S_MUL: state_in = ST_S_DIV;
         ST_S_DIV: begin
            if (div_done) begin
               state_in = (ent_ff.fade || ch_ff == 2'd2) ? ST_S_WB : ST_S_MUL;
            end
         end
         ST_S_WB: state_in = (o_ff < NONE) ? ST_S_RD : ST_S_END;
         ST_S_END: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_in = req_ff;
      ent_in = ent_ff;
      pend_in = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in = rsp_ff;
      rsp_vld_in = 1'b0;
      free_top_in = free_top_ff;
      newest_in = newest_ff;
      oldest_in = oldest_ff;
      cur_in = cur_ff;
      n_in = n_ff;
      o_in = o_ff;
      t0_in = t0_ff;
      first_in = first_ff;
      evict_in = evict_ff;
      t_in = t_ff;
      ch_in = ch_ff;
      ent_we = 1'b0;
      ent_wa = cur_ff;
      ent_wd = ent_ff;
      rd_addr = cur_ff;
      free_rd_addr = free_top_ff;
      newer_wr = '0;
      older_wr = '0;
      free_wr = '0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in.opcode = req_opcode;
               req_in.now = req_current_time;
               req_in.life = req_duration[31] ? DEFAULT_LIFETIME : req_duration;
               req_in.fade = req_alpha_fade;
               req_in.handle = req_shader_handle;
               req_in.color = {req_alpha, req_blue, req_green, req_red};
               cur_in = newest_ff;
               pend_vld_in = 1'b0;
               first_in = 1'b1;
               evict_in = '0;
            end
         end
         ST_EV_RD: rd_addr = oldest_ff;
         ST_EV_CHK: begin
            n_in = lnk_rd.newer;
            o_in = lnk_rd.older;
            first_in = 1'b0;
            if (first_ff) begin
               t0_in = ent_rd.stamp;
            end
            if (ev_match) begin
               older_wr = '{we: lnk_rd.newer < NONE, addr: lnk_rd.newer, data: lnk_rd.older};
               if (lnk_rd.newer >= NONE) begin
                  newest_in = lnk_rd.older;
               end
               free_wr = '{we: 1'b1, addr: oldest_ff, data: free_top_ff};
               free_top_in = oldest_ff;
               evict_in = evict_ff + 7'd1;
            end
         end
         ST_EV_W2: begin
            newer_wr = '{we: o_ff < NONE, addr: o_ff, data: n_ff};
            oldest_in = oldest_nx;
         end
         ST_POP_W: begin
            free_top_in = lnk_rd.free;
            cur_in = free_top_ff;
            ent_we = 1'b1;
            ent_wa = free_top_ff;
            ent_wd = '{stamp: req_ff.now, life: req_ff.life, handle: req_ff.handle,
                       color: req_ff.color, shown: req_ff.color, fade: req_ff.fade};
            newer_wr = '{we: 1'b1, addr: free_top_ff, data: NONE};
            older_wr = '{we: 1'b1, addr: free_top_ff, data: newest_ff};
         end
         ST_LINK: begin
            if (newest_ff < NONE) begin
               newer_wr = '{we: 1'b1, addr: newest_ff, data: cur_ff};
            end else begin
               oldest_in = cur_ff;
            end
            newest_in = cur_ff;
            rsp_vld_in = 1'b1;
            rsp_in = '{kind: KIND_ALLOC, slot: cur_ff[5:0], handle: req_ff.handle,
                       color: req_ff.color, evicted: evict_ff, last: 1'b1};
         end
         ST_S_EVAL: begin
            ent_in = ent_rd;
            n_in = lnk_rd.newer;
            o_in = lnk_rd.older;
            t_in = t_now;
            ch_in = 2'd0;
            if (expired) begin
               older_wr = '{we: lnk_rd.newer < NONE, addr: lnk_rd.newer, data: lnk_rd.older};
               if (lnk_rd.newer >= NONE) begin
                  newest_in = lnk_rd.older;
               end
               free_wr = '{we: 1'b1, addr: cur_ff, data: free_top_ff};
               free_top_in = cur_ff;
            end else if (!fade_now) begin
               if (pend_vld_ff) begin
                  rsp_vld_in = 1'b1;
                  rsp_in = pend_ff;
               end
               pend_vld_in = 1'b1;
               pend_in = '{kind: KIND_LIVE, slot: cur_ff[5:0], handle: ent_rd.handle,
                           color: ent_rd.shown, evicted: '0, last: 1'b0};
               cur_in = lnk_rd.older;
            end
         end
         ST_S_UNL2: begin
            newer_wr = '{we: o_ff < NONE, addr: o_ff, data: n_ff};
            if (o_ff >= NONE) begin
               oldest_in = n_ff;
            end
            cur_in = o_ff;
         end
         ST_S_MUL: div_start = 1'b1;
         ST_S_DIV: begin
            if (div_done) begin
               if (ent_ff.fade) begin
                  ent_in.shown[31:24] = quo;
               end else begin
                  case (ch_ff)
                     2'd0: ent_in.shown[7:0] = quo;
                     2'd1: ent_in.shown[15:8] = quo;
                     default: ent_in.shown[23:16] = quo;
                  endcase
                  ch_in = ch_ff + 2'd1;
               end
            end
         end
         ST_S_WB: begin
            ent_we = 1'b1;
            if (pend_vld_ff) begin
               rsp_vld_in = 1'b1;
               rsp_in = pend_ff;
            end
            pend_vld_in = 1'b1;
            pend_in = '{kind: KIND_LIVE, slot: cur_ff[5:0], handle: ent_ff.handle,
                        color: ent_ff.shown, evicted: '0, last: 1'b0};
            cur_in = o_ff;
         end
         ST_S_END: begin
            if (pend_vld_ff) begin
               rsp_vld_in = 1'b1;
               rsp_in = pend_ff;
               rsp_in.last = 1'b1;
            end
            pend_vld_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         free_top_ff <= '0;
         newest_ff <= NONE;
         oldest_ff <= NONE;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         enabled_ff <= 1'b1;
         first_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         free_top_ff <= free_top_in;
         newest_ff <= newest_in;
         oldest_ff <= oldest_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         first_ff <= first_in;
         if (csr_we) begin
            enabled_ff <= csr_wdata;
         end
      end
      req_ff <= req_in;
      ent_ff <= ent_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
      cur_ff <= cur_in;
      n_ff <= n_in;
      o_ff <= o_in;
      t0_ff <= t0_in;
      evict_ff <= evict_in;
      t_ff <= t_in;
      ch_ff <= ch_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_kind = rsp_ff.kind;
   assign rsp_slot = rsp_ff.slot;
   assign rsp_handle_out = rsp_ff.handle;
   assign rsp_red_out = rsp_ff.color[7:0];
   assign rsp_green_out = rsp_ff.color[15:8];
   assign rsp_blue_out = rsp_ff.color[23:16];
   assign rsp_alpha_out = rsp_ff.color[31:24];
   assign rsp_evicted_count = rsp_ff.evicted;
   assign rsp_last = rsp_ff.last;

   a_alloc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ALLOC |-> rsp_last)
      else $error("allocation report without last");

   a_live_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LIVE |-> rsp_evicted_count == 7'd0)
      else $error("live report with eviction count");

   // head and tail are updated in separate cycles while unlinking
   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (newest_ff == NONE) == (oldest_ff == NONE))
      else $error("list head and tail disagree");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_S_DIV)
      else $error("divider finished outside divide state");
endmodule
